[design/terminal_line_editor_assert.svh]
// Assertion macros shared by the terminal line editor checker.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TLE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tle_pkg.sv]
// Package with the types and constants of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int BUF_SIZE_W     = 7;
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 7'd64;
    localparam logic [BUF_SIZE_W-1:0] LINE_RESERVE   = 7'd2;

    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_INIT = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;

    localparam logic [3:0] RESP_NONE     = 4'd0;
    localparam logic [3:0] RESP_ECHO     = 4'd1;
    localparam logic [3:0] RESP_HASH     = 4'd2;
    localparam logic [3:0] RESP_RUBOUT   = 4'd3;
    localparam logic [3:0] RESP_BELL     = 4'd4;
    localparam logic [3:0] RESP_CANCEL   = 4'd5;
    localparam logic [3:0] RESP_NEWLINE  = 4'd6;
    localparam logic [3:0] RESP_STARTUP  = 4'd7;
    localparam logic [3:0] RESP_PROMPT   = 4'd8;
    localparam logic [3:0] RESP_ABORT    = 4'd9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    typedef enum logic [1:0] {
        MODE_INITIAL,
        MODE_EDIT,
        MODE_PROCESS
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [3:0] response;
        logic [7:0] echo_char;
        logic [5:0] rubout_count;
        logic       line_ready;
        logic [7:0] line_char;
        logic       line_char_valid;
        logic [5:0] line_length;
        logic       line_done;
    } t_out_item;

endpackage

`default_nettype wire

[design/tle_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/terminal_line_editor.sv]
// Top level of the terminal line editor.
// An accepted input's response is registered in the next cycle; the first line character
// passes ST_READ and ST_LOAD. One input per cycle is accepted while o_in_stall is low; a line
// feed reads each character via ST_READ then ST_LOAD, as the RAM read is registered.
// Reset clears mode, count, buffer size (to 64) and the output valid flag.
// The line store has no clearing pass; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_editor #(
    parameter int LINE_BYTES = tle_pkg::LINE_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [6:0]           i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire tle_pkg::t_in_item    i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output tle_pkg::t_out_item        o_out_data
);

    import tle_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [AW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [BUF_SIZE_W-1:0] r_buf_size;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  out_free;
    logic                  accept;
    logic [BUF_SIZE_W-1:0] eff_size;
    logic [BUF_SIZE_W-1:0] cap;
    logic                  has_room;
    logic                  printable;
    logic                  ram_we;
    logic [7:0]            ram_wdata;
    logic                  ram_re;
    logic [7:0]            ram_rdata;
    t_out_item             res;

    tle_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BYTES)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign eff_size  = (r_buf_size > BUF_SIZE_W'(LINE_BYTES)) ?
                       BUF_SIZE_W'(LINE_BYTES) : r_buf_size;
    assign cap       = (eff_size < LINE_RESERVE) ? '0 : eff_size - LINE_RESERVE;
    assign has_room  = BUF_SIZE_W'(r_count) < cap;
    assign printable = (i_in_data.char_in == CH_TAB) ||
                       (i_in_data.char_in inside {[CH_SPACE:CH_DEL]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_INITIAL;
            r_count     <= '0;
            r_idx       <= '0;
            r_buf_size  <= BUF_SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_buf_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_wdata   = i_in_data.char_in;
        ram_re      = 1'b0;
        res         = '0;
        res.line_done = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.action)
                        ACT_INIT: begin
                            if (r_mode == MODE_INITIAL) begin
                                n_mode       = MODE_EDIT;
                                n_count      = '0;
                                res.response = RESP_STARTUP;
                            end
                        end
                        ACT_DONE: begin
                            if (r_mode == MODE_PROCESS) begin
                                n_mode       = MODE_EDIT;
                                n_count      = '0;
                                res.response = RESP_PROMPT;
                            end
                        end
                        ACT_CHAR: begin
                            if (r_mode == MODE_PROCESS && i_in_data.char_in == CH_CAN) begin
                                res.response = RESP_ABORT;
                            end else if (r_mode == MODE_EDIT) begin
                                case (i_in_data.char_in)
                                    CH_NUL, CH_CR: begin
                                        res.response = RESP_NONE;
                                    end
                                    CH_LF: begin
                                        n_mode = MODE_PROCESS;
                                        if (r_count == '0) begin
                                            res.response   = RESP_NEWLINE;
                                            res.line_ready = 1'b1;
                                        end else begin
                                            n_idx   = '0;
                                            n_state = ST_READ;
                                        end
                                    end
                                    CH_BS: begin
                                        if (r_count != '0) begin
                                            n_count      = r_count - AW'(1);
                                            res.response = RESP_RUBOUT;
                                        end else begin
                                            res.response = RESP_BELL;
                                        end
                                    end
                                    CH_CAN: begin
                                        n_count          = '0;
                                        res.response     = RESP_CANCEL;
                                        res.rubout_count = 6'(r_count);
                                    end
                                    default: begin
                                        if (!has_room) begin
                                            res.response = RESP_BELL;
                                        end else if (printable) begin
                                            ram_we        = 1'b1;
                                            n_count       = r_count + AW'(1);
                                            res.response  = RESP_ECHO;
                                            res.echo_char = i_in_data.char_in;
                                        end else begin
                                            ram_we       = 1'b1;
                                            ram_wdata    = CH_HASH;
                                            n_count      = r_count + AW'(1);
                                            res.response = RESP_HASH;
                                        end
                                    end
                                endcase
                            end
                        end
                        default: begin
                            res.response = RESP_NONE;
                        end
                    endcase
                    if (n_state == ST_IDLE) begin
                        n_out_valid = 1'b1;
                        n_out       = res;
                    end
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    res.response        = (r_idx == '0) ? RESP_NEWLINE : RESP_NONE;
                    res.line_ready      = 1'b1;
                    res.line_char       = ram_rdata;
                    res.line_char_valid = 1'b1;
                    res.line_length     = 6'(r_count);
                    res.line_done       = (r_idx + AW'(1)) == r_count;
                    n_out_valid         = 1'b1;
                    n_out               = res;
                    if (res.line_done) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[design/tle_checker.sv]
// Port-level assertion checker for the terminal line editor, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "terminal_line_editor_assert.svh"

module tle_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire tle_pkg::t_out_item o_out_data
);

    import tle_pkg::*;

    `TLE_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    `TLE_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled transaction changed")

    `TLE_ASSERT_IMPLY(a_char_only_in_line, i_clk, i_rst_n, o_out_valid && o_out_data.line_char_valid, o_out_data.line_ready && (o_out_data.line_length != 6'd0), "line character outside line delivery")

    `TLE_ASSERT_IMPLY(a_line_response, i_clk, i_rst_n, o_out_valid && o_out_data.line_ready, o_out_data.response == RESP_NEWLINE || o_out_data.response == RESP_NONE, "bad response during line delivery")

    `TLE_ASSERT_IMPLY(a_echo_only_on_echo, i_clk, i_rst_n, o_out_valid && (o_out_data.response != RESP_ECHO), o_out_data.echo_char == 8'd0, "echo character without echo response")

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

`default_nettype wire
